FILE: rtl/horizontal_weighted_cost_aggregation_defines.svh
// assertion macros for the horizontal weighted cost aggregation block
// used by files that carry concurrent checks; expects clk and rst_n in scope
`ifndef HORIZONTAL_WEIGHTED_COST_AGGREGATION_DEFINES_SVH
`define HORIZONTAL_WEIGHTED_COST_AGGREGATION_DEFINES_SVH

// same-cycle implication, disabled while in reset
`define HWCA_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while in reset
`define HWCA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/hwca_pkg.sv
// shared types and constants for the horizontal weighted cost aggregation block
// no dependencies
`default_nettype none

package hwca_pkg;

  localparam int CFG_DATA_W = 13;
  localparam int CFG_IDX_W  = 1;
  localparam int LW_W       = 13;
  localparam int REACH_W    = 5;

  localparam logic [CFG_IDX_W-1:0] CFG_LINE_WIDTH = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_REACH      = 1'b1;

  localparam logic [LW_W-1:0]    LINE_WIDTH_RST = 13'd640;
  localparam logic [REACH_W-1:0] REACH_RST      = 5'd8;

  typedef struct packed {
    logic [7:0] pixel_cost;
    logic [7:0] pixel_weight;
    logic       frame_end;
  } in_beat_t;

  typedef struct packed {
    logic [7:0] out_cost;
    logic       out_last;
  } out_beat_t;

  // one stored pixel of the delay chain
  typedef struct packed {
    logic [7:0] cost;
    logic [7:0] weight;
  } pix_t;

  // taps of one result handed to the blend pipeline
  typedef struct packed {
    logic       border;
    logic       last;
    logic [7:0] cp;
    logic [7:0] c0;
    logic [7:0] cm;
    logic [7:0] w0;
    logic [7:0] wm;
  } tap_t;

endpackage

`default_nettype wire

FILE: rtl/hwca_cell.sv
// one stage of the pixel delay chain: holds a cost and weight pair
// depends on hwca_pkg
`default_nettype none

module hwca_cell
  import hwca_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic shift_en,
  input  wire pix_t pix_in,
  output pix_t      pix_q
);

  pix_t pix_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pix_r <= '0;
    end else if (shift_en) begin
      pix_r <= pix_in;
    end
  end

  assign pix_q = pix_r;

endmodule

`default_nettype wire

FILE: rtl/hwca_blend.sv
// three-stage weighted blend pipeline, the last stage being the output register
// depends on hwca_pkg
`default_nettype none

module hwca_blend
  import hwca_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      tap_valid,
  input  wire tap_t      tap,
  output logic           tap_ready,
  output logic           out_valid,
  input  wire logic      out_stall,
  output out_beat_t      out_beat
);

  logic       s1_v_r;
  tap_t       s1_r;
  logic       s2_v_r;
  logic       s2_border_r;
  logic       s2_last_r;
  logic [7:0] s2_c0_r;
  logic [15:0] s2_p0_r, s2_p1_r, s2_p2_r;
  logic       o_v_r;
  out_beat_t  o_r;

  logic       o_mv, s2_mv, s1_mv;
  logic [7:0] wc;
  logic [15:0] sum;

  // each stage moves when the one after it is empty or moving
  assign o_mv  = !o_v_r || !out_stall;
  assign s2_mv = !s2_v_r || o_mv;
  assign s1_mv = !s1_v_r || s2_mv;
  assign tap_ready = s1_mv;

  assign wc  = ~(s1_r.w0 + s1_r.wm);
  assign sum = s2_p0_r + s2_p1_r + s2_p2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      o_v_r  <= 1'b0;
    end else begin
      if (s1_mv) s1_v_r <= tap_valid;
      if (s2_mv) s2_v_r <= s1_v_r;
      if (o_mv)  o_v_r  <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_mv) s1_r <= tap;
    if (s2_mv) begin
      s2_border_r <= s1_r.border;
      s2_last_r   <= s1_r.last;
      s2_c0_r     <= s1_r.c0;
      s2_p0_r     <= s1_r.w0 * s1_r.cp;
      s2_p1_r     <= s1_r.wm * s1_r.cm;
      s2_p2_r     <= wc * s1_r.c0;
    end
    if (o_mv) begin
      o_r.out_cost <= s2_border_r ? s2_c0_r : sum[15:8];
      o_r.out_last <= s2_last_r;
    end
  end

  assign out_valid = o_v_r;
  assign out_beat  = o_r;

endmodule

`default_nettype wire

FILE: rtl/horizontal_weighted_cost_aggregation.sv
// path: a pixel's result enters the blend pipeline with the input beat d pixels later and
// reaches out_beat through the blend's s1, s2 and output registers, d being the effective reach
// throughput: one input beat per cycle while in_stall is low; a beat with frame_end stalls input
// while the chain's tail is emitted as copies, and out_stall back-pressure stalls it too
// reset: synchronous active-low rst_n clears the chain, counters, pipeline and
// loads line_width 640 and reach 8
`default_nettype none
`include "horizontal_weighted_cost_aggregation_defines.svh"

module horizontal_weighted_cost_aggregation
  import hwca_pkg::*;
#(
  parameter int MAX_REACH = 31,
  parameter int MAX_WIDTH = 4096
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire in_beat_t              in_beat,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output out_beat_t                  out_beat,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int DEPTH = 2 * MAX_REACH + 1;
  localparam int IW    = $clog2(DEPTH);
  localparam int RW    = $clog2(MAX_REACH + 1);
  localparam int WW    = ($clog2(MAX_WIDTH + 1) > LW_W) ? $clog2(MAX_WIDTH + 1) : LW_W;
  localparam int CW    = $clog2(MAX_WIDTH);

  logic [LW_W-1:0]    line_width_r;
  logic [REACH_W-1:0] reach_r;
  logic [RW-1:0]      in_count_r, in_count_nxt;
  logic [CW-1:0]      col_r, col_nxt;
  logic               flush_r, flush_nxt;
  logic [RW-1:0]      flush_k_r, flush_k_nxt;

  logic [RW-1:0]      eff_d;
  logic [WW-1:0]      eff_w;
  logic [RW-1:0]      ic, ic_after;
  logic               regular;
  logic               border;
  logic               in_acc;
  logic               tap_valid, tap_ready;
  tap_t               tap;
  logic [WW:0]        col_plus_d;
  logic [WW:0]        col_inc;
  logic [IW-1:0]      idx_d, idx_2d, idx_flush;

  pix_t               cell_in [DEPTH];
  pix_t               cell_q  [DEPTH-1];

  // delay chain, entry 0 newest
  genvar gi;
  generate
    for (gi = 0; gi < DEPTH; gi++) begin : g_chain
      if (gi == 0) begin : g_head
        assign cell_in[gi] = '{cost: in_beat.pixel_cost, weight: in_beat.pixel_weight};
      end else begin : g_body
        assign cell_in[gi] = cell_q[gi-1];
      end
      if (gi < DEPTH - 1) begin : g_store
        hwca_cell u_cell (
          .clk      (clk),
          .rst_n    (rst_n),
          .shift_en (in_acc),
          .pix_in   (cell_in[gi]),
          .pix_q    (cell_q[gi])
        );
      end
    end
  endgenerate

  always_comb begin
    if (int'(reach_r) > MAX_REACH) eff_d = RW'(MAX_REACH);
    else                           eff_d = RW'(reach_r);
    if (int'(line_width_r) < 2)              eff_w = WW'(2);
    else if (int'(line_width_r) > MAX_WIDTH) eff_w = WW'(MAX_WIDTH);
    else                                     eff_w = WW'(line_width_r);
  end

  assign in_stall = flush_r || !tap_ready;
  assign in_acc   = in_valid && !in_stall;

  assign ic       = (in_count_r > eff_d) ? eff_d : in_count_r;
  assign regular  = (ic == eff_d);
  assign ic_after = regular ? ic : ic + 1'b1;

  assign col_plus_d = (WW+1)'(col_r) + (WW+1)'(eff_d);
  assign col_inc    = (WW+1)'(col_r) + 1'b1;
  assign border     = ((WW+1)'(col_r) < (WW+1)'(eff_d)) || (col_plus_d >= (WW+1)'(eff_w));

  assign idx_d     = IW'(eff_d);
  assign idx_2d    = IW'({eff_d, 1'b0});
  assign idx_flush = IW'(flush_k_r - 1'b1);

  // taps come from the chain as it stands after this beat shifts in
  always_comb begin
    tap_valid = 1'b0;
    tap       = '0;
    if (flush_r) begin
      tap_valid = 1'b1;
      tap.border = 1'b1;
      tap.last   = (flush_k_r == RW'(1));
      tap.c0     = cell_q[idx_flush].cost;
    end else begin
      tap_valid  = in_acc && regular;
      tap.border = border;
      tap.last   = in_beat.frame_end && (ic_after == '0);
      tap.cp     = cell_in[0].cost;
      tap.c0     = cell_in[idx_d].cost;
      tap.cm     = cell_in[idx_2d].cost;
      tap.w0     = cell_in[idx_d].weight;
      tap.wm     = cell_in[idx_2d].weight;
    end
  end

  always_comb begin
    in_count_nxt = in_count_r;
    col_nxt      = col_r;
    flush_nxt    = flush_r;
    flush_k_nxt  = flush_k_r;
    if (flush_r && tap_ready) begin
      flush_k_nxt = flush_k_r - 1'b1;
      if (flush_k_r == RW'(1)) flush_nxt = 1'b0;
    end
    if (in_acc) begin
      in_count_nxt = ic_after;
      if (regular) begin
        col_nxt = (col_inc >= (WW+1)'(eff_w)) ? '0 : CW'(col_inc);
      end
      if (in_beat.frame_end) begin
        in_count_nxt = '0;
        col_nxt      = '0;
        flush_k_nxt  = ic_after;
        flush_nxt    = (ic_after != '0);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_width_r <= LINE_WIDTH_RST;
      reach_r      <= REACH_RST;
      in_count_r   <= '0;
      col_r        <= '0;
      flush_r      <= 1'b0;
      flush_k_r    <= '0;
    end else begin
      in_count_r <= in_count_nxt;
      col_r      <= col_nxt;
      flush_r    <= flush_nxt;
      flush_k_r  <= flush_k_nxt;
      if (cfg_we) begin
        case (cfg_index)
          CFG_LINE_WIDTH: line_width_r <= cfg_data[LW_W-1:0];
          CFG_REACH:      reach_r      <= cfg_data[REACH_W-1:0];
          default: ;
        endcase
      end
    end
  end

  hwca_blend u_blend (
    .clk       (clk),
    .rst_n     (rst_n),
    .tap_valid (tap_valid),
    .tap       (tap),
    .tap_ready (tap_ready),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_beat  (out_beat)
  );

  `HWCA_ASSERT_NEXT(a_frame_end_clears, in_acc && in_beat.frame_end, in_count_r == '0 && col_r == '0, "frame end did not clear counters")
  `HWCA_ASSERT_SAME(a_flush_count_live, flush_r, flush_k_r != '0, "flush running with zero count")
  `HWCA_ASSERT_NEXT(a_flush_stops, flush_r && tap_ready && flush_k_r == RW'(1), !flush_r, "flush ran past its last copy")

endmodule

`default_nettype wire

FILE: test/tb_horizontal_weighted_cost_aggregation.sv
// self-checking testbench for horizontal_weighted_cost_aggregation
// needs hwca_pkg and the block's rtl; a tracker class predicts every output beat
module tb_horizontal_weighted_cost_aggregation
  import hwca_pkg::*;
;

  localparam int unsigned CYCLE_LIMIT = 300000;
  localparam int unsigned SETTLE_CYCLES = 12;

  // predicts the aggregated cost stream and checks the block's output beats
  class aggregated_cost_tracker;
    logic [LW_W-1:0]    line_width;
    logic [REACH_W-1:0] reach;
    logic [7:0]         cost_line[63];
    logic [7:0]         weight_line[63];
    int unsigned        in_count;
    logic [11:0]        out_column;
    out_beat_t          expected_costs[$];
    int unsigned        mismatches;

    function new();
      line_width = LINE_WIDTH_RST;
      reach = REACH_RST;
      foreach (cost_line[k]) begin
        cost_line[k] = 8'd0;
        weight_line[k] = 8'd0;
      end
      in_count = 0;
      out_column = '0;
      mismatches = 0;
    endfunction

    function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
      case (idx)
        CFG_LINE_WIDTH: line_width = value[LW_W-1:0];
        CFG_REACH: reach = value[REACH_W-1:0];
        default: ;
      endcase
    endfunction

    function int unsigned row_pixels();
      int unsigned w;
      w = line_width;
      if (w < 2) w = 2;
      if (w > 4096) w = 4096;
      return w;
    endfunction

    function logic [7:0] blend(int unsigned d);
      int unsigned cp, c0, cm, w0, wm, wc, acc;
      cp = cost_line[0];
      c0 = cost_line[d];
      cm = cost_line[2*d];
      w0 = weight_line[d];
      wm = weight_line[2*d];
      wc = 255 - ((w0 + wm) & 255);
      acc = (w0 * cp + wm * cm + wc * c0) & 32'hFFFF;
      return acc[15:8];
    endfunction

    function void take_pixel(in_beat_t b);
      int unsigned d, width, col, tail;
      bit has_cost;
      out_beat_t r;
      d = reach;
      width = row_pixels();
      tail = 0;
      has_cost = 1'b0;
      r = '0;
      for (int k = 62; k > 0; k--) begin
        cost_line[k] = cost_line[k-1];
        weight_line[k] = weight_line[k-1];
      end
      cost_line[0] = b.pixel_cost;
      weight_line[0] = b.pixel_weight;
      // a smaller reach written mid-frame drops the pixels in between
      if (in_count > d) in_count = d;
      if (in_count >= d) begin
        col = out_column;
        if (col < d || col + d >= width) r.out_cost = cost_line[d];
        else r.out_cost = blend(d);
        has_cost = 1'b1;
        col++;
        if (col >= width) col = 0;
        out_column = col[11:0];
      end else begin
        in_count++;
      end
      if (b.frame_end) begin
        tail = (in_count < d) ? in_count : d;
        if (has_cost && tail == 0) r.out_last = 1'b1;
      end
      if (has_cost) expected_costs.push_back(r);
      if (b.frame_end) begin
        // flush the delay chain tail oldest first, unchanged
        for (int k = tail; k > 0; k--) begin
          r.out_cost = cost_line[k-1];
          r.out_last = (k == 1);
          expected_costs.push_back(r);
        end
        in_count = 0;
        out_column = '0;
      end
    endfunction

    function void check_cost(out_beat_t got);
      out_beat_t want;
      if (expected_costs.size() == 0) begin
        $error("unexpected output beat: out_cost %0d out_last %0d", got.out_cost, got.out_last);
        mismatches++;
        return;
      end
      want = expected_costs.pop_front();
      if (got.out_cost !== want.out_cost) begin
        $error("out_cost: expected %0d, actual %0d", want.out_cost, got.out_cost);
        mismatches++;
      end
      if (got.out_last !== want.out_last) begin
        $error("out_last: expected %0d, actual %0d", want.out_last, got.out_last);
        mismatches++;
      end
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  in_beat_t              in_beat = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  out_beat_t             out_beat;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = CFG_LINE_WIDTH;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  aggregated_cost_tracker tracker;
  bit                     idling_on = 1'b1;
  int unsigned            cycle_count = 0;

  horizontal_weighted_cost_aggregation dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_beat   (in_beat),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_beat  (out_beat),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("horizontal_weighted_cost_aggregation regression: fail");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) tracker.check_cost(out_beat);
  end

  // receiver backpressure in bursts, with quiet stretches between
  initial begin
    forever begin
      if (idling_on && $urandom_range(0, 2) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 7)) @(posedge clk);
      end else begin
        out_stall <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
    end
  end

  function automatic in_beat_t pixel(logic [7:0] c, logic [7:0] w, logic e);
    in_beat_t b;
    b.pixel_cost = c;
    b.pixel_weight = w;
    b.frame_end = e;
    return b;
  endfunction

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 7))
      0: return 8'd0;
      1: return 8'd255;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic drive_pixel(in_beat_t b);
    if (idling_on && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_beat <= b;
    do @(posedge clk); while (in_stall);
    tracker.take_pixel(b);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (tracker.expected_costs.size() != 0) @(posedge clk);
    // pixels still filling the chain leave no expectation behind
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic load_geometry(logic [LW_W-1:0] lw, logic [REACH_W-1:0] rch);
    logic [CFG_DATA_W-1:0] reach_word;
    settle();
    // upper bits beyond the reach field are don't-care
    reach_word = {8'($urandom_range(0, 255)), rch};
    cfg_we <= 1'b1;
    cfg_index <= CFG_LINE_WIDTH;
    cfg_data <= lw;
    @(posedge clk);
    tracker.set_register(CFG_LINE_WIDTH, lw);
    cfg_index <= CFG_REACH;
    cfg_data <= reach_word;
    @(posedge clk);
    tracker.set_register(CFG_REACH, reach_word);
    cfg_we <= 1'b0;
  endtask

  // mostly whole rows per frame, some short frames of random length
  task automatic stream_pixels(int unsigned total);
    int unsigned sent, run, row_w;
    sent = 0;
    while (sent < total) begin
      row_w = tracker.row_pixels();
      if (row_w <= 64 && $urandom_range(0, 4) != 0) run = row_w * $urandom_range(1, 3);
      else run = $urandom_range(1, 2 * tracker.reach + 12);
      for (int i = 0; i < run && sent < total; i++) begin
        drive_pixel(pixel(pick_byte(), pick_byte(), i == run - 1));
        sent++;
      end
    end
    in_valid <= 1'b0;
  endtask

  initial begin
    tracker = new();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset geometry: short frame that never fills the chain, so only the flushed tail comes out
    drive_pixel(pixel(8'd255, 8'd0, 1'b0));
    drive_pixel(pixel(8'd0, 8'd255, 1'b0));
    drive_pixel(pixel(8'd255, 8'd255, 1'b0));
    drive_pixel(pixel(8'd0, 8'd0, 1'b0));
    drive_pixel(pixel(8'd128, 8'd1, 1'b0));
    drive_pixel(pixel(8'd1, 8'd254, 1'b1));

    // interior blends across a row wrap
    load_geometry(13'd6, 5'd2);
    drive_pixel(pixel(8'd255, 8'd255, 1'b0));
    drive_pixel(pixel(8'd255, 8'd255, 1'b0));
    drive_pixel(pixel(8'd255, 8'd255, 1'b0));
    drive_pixel(pixel(8'd0, 8'd255, 1'b0));
    drive_pixel(pixel(8'd255, 8'd0, 1'b0));
    drive_pixel(pixel(8'd200, 8'd128, 1'b0));
    drive_pixel(pixel(8'd17, 8'd200, 1'b0));
    drive_pixel(pixel(8'd99, 8'd77, 1'b1));
    drive_pixel(pixel(8'd42, 8'd0, 1'b1));

    // zero reach: every pixel goes through the formula
    load_geometry(13'd3, 5'd0);
    drive_pixel(pixel(8'd255, 8'd255, 1'b0));
    drive_pixel(pixel(8'd255, 8'd128, 1'b0));
    drive_pixel(pixel(8'd0, 8'd1, 1'b1));

    // row narrower than twice the reach
    load_geometry(13'd3, 5'd2);
    drive_pixel(pixel(8'd10, 8'd255, 1'b0));
    drive_pixel(pixel(8'd255, 8'd255, 1'b0));
    drive_pixel(pixel(8'd30, 8'd2, 1'b0));
    drive_pixel(pixel(8'd255, 8'd255, 1'b1));

    // reach lowered mid-frame clamps the fill count
    load_geometry(13'd6, 5'd3);
    drive_pixel(pixel(8'd5, 8'd6, 1'b0));
    drive_pixel(pixel(8'd7, 8'd8, 1'b0));
    drive_pixel(pixel(8'd9, 8'd10, 1'b0));
    load_geometry(13'd6, 5'd1);
    drive_pixel(pixel(8'd11, 8'd12, 1'b0));
    drive_pixel(pixel(8'd13, 8'd14, 1'b1));

    load_geometry(13'd16, 5'd3);
    stream_pixels(70);
    load_geometry(13'd2, 5'd0);
    stream_pixels(30);
    load_geometry(13'd8191, 5'd31);
    stream_pixels(40);
    load_geometry(13'd0, 5'd31);
    stream_pixels(30);
    load_geometry(13'd40, 5'd5);
    stream_pixels(60);
    load_geometry(13'd4096, 5'd1);
    stream_pixels(30);
    load_geometry(13'd7, 5'd4);
    stream_pixels(40);
    load_geometry(13'd25, 5'd12);
    stream_pixels(60);
    idling_on = 1'b0;
    load_geometry(13'd64, 5'd2);
    stream_pixels(60);

    settle();
    if (tracker.mismatches == 0) begin
      $display("horizontal_weighted_cost_aggregation regression: pass");
    end else begin
      $display("horizontal_weighted_cost_aggregation regression: fail");
    end
    $finish;
  end

endmodule
